FILE: design/gda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_pkg
// shared widths, types and calendar helpers for the date adder
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned AccW    = 17;
  localparam int unsigned Mod400W = 9;

  localparam logic [YearW-1:0]   YearMax     = YearW'(9999);
  localparam logic [OffsetW-1:0] OffsetReset = OffsetW'(10000);
  localparam logic [AccW-1:0]    Len400      = AccW'(400);
  localparam logic [AccW-1:0]    LenLeapYear = AccW'(366);
  localparam logic [AccW-1:0]    LenYear     = AccW'(365);
  localparam logic [MonthW-1:0]  MonthJan    = MonthW'(1);
  localparam logic [MonthW-1:0]  MonthDec    = MonthW'(12);
  localparam logic [MonthW-1:0]  MonthFeb    = MonthW'(2);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMod  = 7'b0000010,
    StOrd  = 7'b0000100,
    StAdd  = 7'b0001000,
    StYear = 7'b0010000,
    StMon  = 7'b0100000,
    StFin  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [AccW-1:0] a;
    logic [AccW-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic [AccW-1:0] res;
    logic            gt;
    logic            ge;
  } alu_rsp_t;

  // leap test from the low year bits and the year modulo 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [Mod400W-1:0] m400);
    logic cent;
    cent = (m400 == Mod400W'(0)) || (m400 == Mod400W'(100)) ||
           (m400 == Mod400W'(200)) || (m400 == Mod400W'(300));
    return ((y_lo == 2'd0) && !cent) || (m400 == Mod400W'(0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic leap, input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m) inside
      MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11): len = DayW'(30);
      MonthFeb: len = leap ? DayW'(29) : DayW'(28);
      default: len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: design/gda_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_in_if
// start date channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface gda_in_if;
  logic                       valid;
  logic                       ready;
  logic [gda_pkg::YearW-1:0]  start_year;
  logic [gda_pkg::MonthW-1:0] start_month;
  logic [gda_pkg::DayW-1:0]   start_day;

  modport source (output valid, start_year, start_month, start_day, input ready);
  modport sink   (input valid, start_year, start_month, start_day, output ready);
endinterface
`default_nettype wire

FILE: design/gda_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_out_if
// result date channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface gda_out_if;
  logic                       valid;
  logic                       ready;
  logic [gda_pkg::YearW-1:0]  end_year;
  logic [gda_pkg::MonthW-1:0] end_month;
  logic [gda_pkg::DayW-1:0]   end_day;
  logic                       overflow;

  modport source (output valid, end_year, end_month, end_day, overflow, input ready);
  modport sink   (input valid, end_year, end_month, end_day, overflow, output ready);
endinterface
`default_nettype wire

FILE: design/gregorian_date_add_days.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// adds a programmable day count to a gregorian date
// ----------------------------------------------------------------------------
// One date is worked on at a time; in_i.ready is high only while the block is
// idle. Every step goes through the single add/compare unit: first the start
// year is reduced modulo 400 for the leap test, then month lengths are summed
// into a day-of-year count, the offset is added, and the count is walked down
// one year and then one month per cycle. A finished date sits in an output
// register, so the next date is taken while the previous one waits.
// The day offset (offset_q) resets to 10000 and is written through
// cfg_we_i/cfg_wdata_i.
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  gda_in_if.sink                            in_i,
  gda_out_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [gda_pkg::OffsetW-1:0]  cfg_wdata_i
);
  import gda_pkg::*;

  state_e               state_q, state_d;
  logic [OffsetW-1:0]   offset_q;
  logic [YearW:0]       year_q, year_d;
  logic [YearW-1:0]     r_q, r_d;
  logic [MonthW-1:0]    month_q, month_d;
  logic [MonthW-1:0]    idx_q, idx_d;
  logic [DayW-1:0]      day_q, day_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic                 ovalid_q, ovalid_d;
  logic [YearW-1:0]     oyear_q;
  logic [MonthW-1:0]    omonth_q;
  logic [DayW-1:0]      oday_q;
  logic                 oovf_q;
  logic                 load_out;
  logic                 leap;
  logic [DayW-1:0]      mlen_cur;
  logic [DayW-1:0]      mlen_idx;
  logic [AccW-1:0]      ylen;
  logic                 big_year;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  gda_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign leap     = is_leap(year_q[1:0], r_q[Mod400W-1:0]);
  assign mlen_cur = month_len(leap, month_q);
  assign mlen_idx = month_len(leap, idx_q);
  assign ylen     = leap ? LenLeapYear : LenYear;
  assign big_year = year_q > {1'b0, YearMax};
  assign load_out = (state_q == StFin) && (!ovalid_q || out_o.ready);

  assign in_i.ready     = (state_q == StIdle);
  assign out_o.valid    = ovalid_q;
  assign out_o.end_year  = oyear_q;
  assign out_o.end_month = omonth_q;
  assign out_o.end_day   = oday_q;
  assign out_o.overflow  = oovf_q;

  // operand select for the shared unit
  always_comb begin
    alu_req.a   = acc_q;
    alu_req.b   = ylen;
    alu_req.sub = 1'b1;
    case (state_q)
      StMod: begin
        alu_req.a = AccW'(r_q);
        alu_req.b = Len400;
      end
      StOrd: begin
        alu_req.b   = AccW'(mlen_idx);
        alu_req.sub = 1'b0;
      end
      StAdd: begin
        alu_req.b   = AccW'(offset_q);
        alu_req.sub = 1'b0;
      end
      StMon: begin
        alu_req.b = AccW'(mlen_cur);
      end
      default: begin
        alu_req.b = ylen;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    year_d  = year_q;
    r_d     = r_q;
    month_d = month_q;
    idx_d   = idx_q;
    day_d   = day_q;
    acc_d   = acc_q;
    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          year_d  = (in_i.start_year == '0) ? (YearW+1)'(1) : {1'b0, in_i.start_year};
          r_d     = (in_i.start_year == '0) ? YearW'(1) : in_i.start_year;
          month_d = (in_i.start_month == '0) ? MonthJan :
                    (in_i.start_month > MonthDec) ? MonthDec : in_i.start_month;
          day_d   = (in_i.start_day == '0) ? DayW'(1) : in_i.start_day;
          state_d = StMod;
        end
      end
      StMod: begin
        if (alu_rsp.ge) begin
          r_d = alu_rsp.res[YearW-1:0];
        end else begin
          acc_d   = (day_q > mlen_cur) ? AccW'(mlen_cur) : AccW'(day_q);
          idx_d   = MonthJan;
          state_d = StOrd;
        end
      end
      StOrd: begin
        if (idx_q < month_q) begin
          acc_d = alu_rsp.res;
          idx_d = idx_q + MonthW'(1);
        end else begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        acc_d   = alu_rsp.res;
        state_d = StYear;
      end
      StYear: begin
        if (alu_rsp.gt) begin
          acc_d  = alu_rsp.res;
          year_d = year_q + (YearW+1)'(1);
          r_d    = (r_q == YearW'(399)) ? '0 : r_q + YearW'(1);
        end else begin
          month_d = MonthJan;
          state_d = StMon;
        end
      end
      StMon: begin
        if ((month_q < MonthDec) && alu_rsp.gt) begin
          acc_d   = alu_rsp.res;
          month_d = month_q + MonthW'(1);
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      offset_q <= OffsetReset;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    r_q     <= r_d;
    month_q <= month_d;
    idx_q   <= idx_d;
    day_q   <= day_d;
    acc_q   <= acc_d;
    if (load_out) begin
      oyear_q  <= big_year ? YearMax : year_q[YearW-1:0];
      omonth_q <= month_q;
      oday_q   <= acc_q[DayW-1:0];
      oovf_q   <= big_year;
    end
  end

endmodule
`default_nettype wire

FILE: design/gda_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gda_alu
// shared add/subtract and compare unit of the date walk
// ----------------------------------------------------------------------------
module gda_alu (
  input  gda_pkg::alu_req_t req_i,
  output gda_pkg::alu_rsp_t rsp_o
);
  import gda_pkg::*;

  always_comb begin
    rsp_o.res = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
    rsp_o.gt  = req_i.a > req_i.b;
    rsp_o.ge  = req_i.a >= req_i.b;
  end
endmodule
`default_nettype wire
